### rtl/quaternion_to_euler_xyz_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle block
// Concurrent checks on clock, disabled while reset is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_XYZ_DEFINES_SVH
`define QUATERNION_TO_EULER_XYZ_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define Q2E_ASSERT(label, prop, msg)
`define Q2E_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Widths, constants, arctangent table and cell types of the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int CORDIC_STAGES_DEF = 16;

   // vector lanes and angle accumulator
   localparam int VEC_W = 36;
   localparam int ANG_W = 35;

   // square root datapath: radicand up to 2^60, one result bit per cell
   localparam int SQRT_CELLS = 31;
   localparam int RAD_W      = 62;

   localparam int PITCH_W = 15;
   localparam int ANGLE_W = 16;

   localparam logic signed [VEC_W-1:0]   ONE_Q30     = VEC_W'(64'sd1073741824);
   localparam logic signed [ANG_W-1:0]   PI_Q30      = ANG_W'(64'sd3373259426);
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

   typedef struct packed {
      logic signed [VEC_W-1:0] s;
      logic signed [VEC_W-1:0] yaw_y;
      logic signed [VEC_W-1:0] yaw_x;
      logic signed [VEC_W-1:0] roll_y;
      logic signed [VEC_W-1:0] roll_x;
      logic                    clamp;
   } side_type;

   typedef struct packed {
      logic             valid;
      logic [RAD_W-1:0] rem;
      logic [RAD_W-1:0] res;
      side_type         side;
   } sqrt_cell_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic       valid;
      logic       clamp;
      logic       spos;
      logic [2:0] zero;
   } flag_type;

   // atan(2^-i) in Q.30, rounded
   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [ANG_W-1:0] a;
      unique case (i)
         5'd0:  a = 35'sd843314857;
         5'd1:  a = 35'sd497837829;
         5'd2:  a = 35'sd263043837;
         5'd3:  a = 35'sd133525159;
         5'd4:  a = 35'sd67021687;
         5'd5:  a = 35'sd33543516;
         5'd6:  a = 35'sd16775851;
         5'd7:  a = 35'sd8388437;
         5'd8:  a = 35'sd4194283;
         5'd9:  a = 35'sd2097149;
         5'd10: a = 35'sd1048576;
         5'd11: a = 35'sd524288;
         5'd12: a = 35'sd262144;
         5'd13: a = 35'sd131072;
         5'd14: a = 35'sd65536;
         5'd15: a = 35'sd32768;
         5'd16: a = 35'sd16384;
         5'd17: a = 35'sd8192;
         5'd18: a = 35'sd4096;
         5'd19: a = 35'sd2048;
         5'd20: a = 35'sd1024;
         5'd21: a = 35'sd512;
         5'd22: a = 35'sd256;
         5'd23: a = 35'sd128;
         5'd24: a = 35'sd64;
         5'd25: a = 35'sd32;
         5'd26: a = 35'sd16;
         5'd27: a = 35'sd8;
         5'd28: a = 35'sd4;
         5'd29: a = 35'sd2;
         5'd30: a = 35'sd1;
         5'd31: a = 35'sd0;
      endcase
      return a;
   endfunction

endpackage

### rtl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit step of the integer square root; passes the remainder, the
// partial root and the other operands of the request to the next cell.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell import q2e_pkg::*; #(
   parameter int DIGIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  sqrt_cell_type prev_cell,
   output sqrt_cell_type next_cell
);

   localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_CELLS - 1 - DIGIT));

   sqrt_cell_type cell_ff, cell_in;
   logic [RAD_W-1:0] trial;

   // compare against root plus digit, subtract and shift
   always_comb begin
      cell_in = prev_cell;
      trial   = prev_cell.res + BIT;
      if (prev_cell.rem >= trial) begin
         cell_in.rem = prev_cell.rem - trial;
         cell_in.res = (prev_cell.res >> 1) + BIT;
      end else begin
         cell_in.res = prev_cell.res >> 1;
      end
   end

   // advance; reset clears only the valid bit
   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign next_cell = cell_ff;

endmodule

### rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation: turns the vector toward the x axis
// and adds the matching arctangent to the angle, or subtracts it when y is negative.
// ----------------------------------------------------------------------------
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic           clock,
   input  logic           en,
   input  cordic_vec_type prev_vec,
   output cordic_vec_type next_vec
);

   cordic_vec_type vec_ff, vec_in;
   logic signed [VEC_W-1:0] dx, dy;
   logic signed [ANG_W-1:0] step_angle;

   // rotate by the sign of y
   always_comb begin
      dx         = prev_vec.y >>> STAGE;
      dy         = prev_vec.x >>> STAGE;
      step_angle = atan_q30(5'(STAGE));
      if (prev_vec.y < 0) begin
         vec_in.x = prev_vec.x - dx;
         vec_in.y = prev_vec.y + dy;
         vec_in.z = prev_vec.z - step_angle;
      end else begin
         vec_in.x = prev_vec.x + dx;
         vec_in.y = prev_vec.y - dy;
         vec_in.z = prev_vec.z + step_angle;
      end
   end

   // hand to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign next_vec = vec_ff;

endmodule

### rtl/quaternion_to_euler_xyz.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_xyz
// Converts a Q1.15 unit quaternion to X-Y-Z Euler angles in Q3.13 radians (pitch in Q2.13).
// ----------------------------------------------------------------------------
// A fully pipelined block: it accepts one quaternion every clock while
// req_stall is low and returns one result per request, in order. Its rows: the
// products, the sums, the squared pitch sine, the radicand, a row of 31
// square-root cells that forms cos(pitch), one pre-rotation stage, three
// lanes of CORDIC_STAGES vectoring cells each in lockstep for pitch, yaw and
// roll, a rounding stage and the output register. A two-entry output
// register plus skid keeps requests flowing while a result waits; req_stall
// rises only when both are full. Pitch near plus or minus pi/2 is clamped
// and flagged on rsp_pitch_clamped. The input is not renormalized.
`include "quaternion_to_euler_xyz_defines.svh"

module quaternion_to_euler_xyz import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [15:0]        req_quat_w,
   input  logic signed [15:0]        req_quat_x,
   input  logic signed [15:0]        req_quat_y,
   input  logic signed [15:0]        req_quat_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [ANGLE_W-1:0] rsp_yaw_angle,
   output logic signed [ANGLE_W-1:0] rsp_roll_angle,
   output logic                      rsp_pitch_clamped
);

   logic adv;

   // products
   logic st1_valid_ff;
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xz_ff, p_wy_ff, p_xy_ff, p_wz_ff;
   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff;

   // sums
   logic st2_valid_ff, st2_valid_in;
   side_type st2_ff, st2_in;

   // pitch sine squared
   logic st3_valid_ff;
   logic [RAD_W-1:0] sq_ff;
   side_type st3_ff;
   logic signed [30:0] s_narrow;

   // square root chain
   sqrt_cell_type sqrt_w [SQRT_CELLS+1];
   sqrt_cell_type sqrt_head_ff;

   // pre-rotation and CORDIC chain
   cordic_vec_type pre_in [3];
   cordic_vec_type pre_ff [3];
   cordic_vec_type chain_w [3][CORDIC_STAGES+1];
   flag_type pre_flag_ff, pre_flag_in;
   flag_type flag_ff [CORDIC_STAGES];
   logic signed [VEC_W-1:0] lane_y [3];
   logic signed [VEC_W-1:0] lane_x [3];
   side_type sqrt_side;

   // rounded result
   logic fin_valid_ff;
   logic signed [PITCH_W-1:0] fin_pitch_ff, fin_pitch_in;
   logic signed [ANGLE_W-1:0] fin_yaw_ff, fin_roll_ff;
   logic fin_clamped_ff;
   flag_type last_flag;

   // output register and skid
   logic rsp_valid_ff, skid_valid_ff, take;
   logic signed [PITCH_W-1:0] rsp_pitch_ff, skid_pitch_ff;
   logic signed [ANGLE_W-1:0] rsp_yaw_ff, rsp_roll_ff, skid_yaw_ff, skid_roll_ff;
   logic rsp_clamped_ff, skid_clamped_ff;

   // round Q.30 to Q3.13, halves up, and saturate to +-lim
   function automatic logic signed [ANGLE_W-1:0] round_sat(
      input logic signed [ANG_W-1:0]   z,
      input logic signed [ANGLE_W-1:0] lim
   );
      logic signed [ANG_W:0]    t;
      logic signed [ANG_W-17:0] q;
      logic signed [ANG_W-17:0] l;
      logic signed [ANGLE_W-1:0] r;
      t = (ANG_W+1)'(z) + (ANG_W+1)'(65536);
      q = $signed(t[ANG_W:17]);
      l = (ANG_W-16)'(lim);
      if (q > l) begin
         r = lim;
      end else if (q < -l) begin
         r = -lim;
      end else begin
         r = ANGLE_W'(q);
      end
      return r;
   endfunction

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // form the nine products
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_valid_ff <= req_valid;
         p_wx_ff <= req_quat_w * req_quat_x;
         p_yz_ff <= req_quat_y * req_quat_z;
         p_xz_ff <= req_quat_x * req_quat_z;
         p_wy_ff <= req_quat_w * req_quat_y;
         p_xy_ff <= req_quat_x * req_quat_y;
         p_wz_ff <= req_quat_w * req_quat_z;
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
      end
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end
   end

   // combine products into the atan2 operands
   always_comb begin
      st2_valid_in  = st1_valid_ff;
      st2_in.s      = (VEC_W'(p_wx_ff) - VEC_W'(p_yz_ff)) <<< 1;
      st2_in.yaw_y  = (VEC_W'(p_xz_ff) + VEC_W'(p_wy_ff)) <<< 1;
      st2_in.yaw_x  = ONE_Q30 - ((VEC_W'(p_xx_ff) + VEC_W'(p_yy_ff)) <<< 1);
      st2_in.roll_y = (VEC_W'(p_xy_ff) + VEC_W'(p_wz_ff)) <<< 1;
      st2_in.roll_x = ONE_Q30 - ((VEC_W'(p_xx_ff) + VEC_W'(p_zz_ff)) <<< 1);
      st2_in.clamp  = (st2_in.s >= ONE_Q30) || (st2_in.s <= -ONE_Q30);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st2_valid_ff <= st2_valid_in;
         st2_ff       <= st2_in;
      end
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end
   end

   // square the pitch sine; its value matters only when not clamped
   assign s_narrow = st2_ff.s[30:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         st3_valid_ff <= st2_valid_ff;
         st3_ff       <= st2_ff;
         sq_ff        <= $unsigned(RAD_W'(s_narrow) * RAD_W'(s_narrow));
      end
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end
   end

   // load the radicand 1 - s*s into the root chain
   always_ff @(posedge clock) begin
      if (adv) begin
         sqrt_head_ff.valid <= st3_valid_ff;
         sqrt_head_ff.rem   <= (RAD_W'(1) << 60) - sq_ff;
         sqrt_head_ff.res   <= '0;
         sqrt_head_ff.side  <= st3_ff;
      end
      if (reset) begin
         sqrt_head_ff.valid <= 1'b0;
      end
   end

   assign sqrt_w[0] = sqrt_head_ff;

   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      q2e_sqrt_cell #(.DIGIT(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .prev_cell (sqrt_w[k]),
         .next_cell (sqrt_w[k+1])
      );
   end

   // turn vectors with negative x by pi
   assign sqrt_side = sqrt_w[SQRT_CELLS].side;
   assign lane_y[0] = sqrt_side.s;
   assign lane_x[0] = $signed({{(VEC_W-31){1'b0}}, sqrt_w[SQRT_CELLS].res[30:0]});
   assign lane_y[1] = sqrt_side.yaw_y;
   assign lane_x[1] = sqrt_side.yaw_x;
   assign lane_y[2] = sqrt_side.roll_y;
   assign lane_x[2] = sqrt_side.roll_x;

   always_comb begin
      pre_flag_in.valid = sqrt_w[SQRT_CELLS].valid;
      pre_flag_in.clamp = sqrt_side.clamp;
      pre_flag_in.spos  = sqrt_side.s > 0;
      for (int l = 0; l < 3; l++) begin
         pre_flag_in.zero[l] = (lane_x[l] == '0) && (lane_y[l] == '0);
         if (lane_x[l] < 0) begin
            pre_in[l].x = -lane_x[l];
            pre_in[l].y = -lane_y[l];
            pre_in[l].z = (lane_y[l] >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            pre_in[l].x = lane_x[l];
            pre_in[l].y = lane_y[l];
            pre_in[l].z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff      <= pre_in;
         pre_flag_ff <= pre_flag_in;
      end
      if (reset) begin
         pre_flag_ff.valid <= 1'b0;
      end
   end

   // three lanes of micro-rotation cells in lockstep
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign chain_w[l][0] = pre_ff[l];
      for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
         q2e_cordic_cell #(.STAGE(k)) u_cell (
            .clock    (clock),
            .en       (adv),
            .prev_vec (chain_w[l][k]),
            .next_vec (chain_w[l][k+1])
         );
      end
   end

   // carry valid and flags beside the cells
   always_ff @(posedge clock) begin
      if (adv) begin
         flag_ff[0] <= pre_flag_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
      if (reset) begin
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            flag_ff[k].valid <= 1'b0;
         end
      end
   end

   assign last_flag = flag_ff[CORDIC_STAGES-1];

   // round, saturate, apply the clamp and zero the angle of a null vector
   always_comb begin
      if (last_flag.clamp) begin
         fin_pitch_in = last_flag.spos ? PITCH_W'(HALF_PI_Q13) : PITCH_W'(-HALF_PI_Q13);
      end else if (last_flag.zero[0]) begin
         fin_pitch_in = '0;
      end else begin
         fin_pitch_in = PITCH_W'(round_sat(chain_w[0][CORDIC_STAGES].z, HALF_PI_Q13));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_valid_ff   <= last_flag.valid;
         fin_pitch_ff   <= fin_pitch_in;
         fin_yaw_ff     <= last_flag.zero[1] ? '0 :
                           round_sat(chain_w[1][CORDIC_STAGES].z, PI_Q13);
         fin_roll_ff    <= last_flag.zero[2] ? '0 :
                           round_sat(chain_w[2][CORDIC_STAGES].z, PI_Q13);
         fin_clamped_ff <= last_flag.clamp;
      end
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end
   end

   // deliver to the output register, park in the skid when it is blocked
   assign take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_pitch_ff   <= skid_pitch_ff;
            rsp_yaw_ff     <= skid_yaw_ff;
            rsp_roll_ff    <= skid_roll_ff;
            rsp_clamped_ff <= skid_clamped_ff;
            skid_valid_ff  <= 1'b0;
         end
      end else if (fin_valid_ff) begin
         if (!rsp_valid_ff || take) begin
            rsp_pitch_ff   <= fin_pitch_ff;
            rsp_yaw_ff     <= fin_yaw_ff;
            rsp_roll_ff    <= fin_roll_ff;
            rsp_clamped_ff <= fin_clamped_ff;
            rsp_valid_ff   <= 1'b1;
         end else begin
            skid_pitch_ff   <= fin_pitch_ff;
            skid_yaw_ff     <= fin_yaw_ff;
            skid_roll_ff    <= fin_roll_ff;
            skid_clamped_ff <= fin_clamped_ff;
            skid_valid_ff   <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pitch_angle   = rsp_pitch_ff;
   assign rsp_yaw_angle     = rsp_yaw_ff;
   assign rsp_roll_angle    = rsp_roll_ff;
   assign rsp_pitch_clamped = rsp_clamped_ff;

   `Q2E_ASSERT(a_skid_behind_out, skid_valid_ff |-> rsp_valid_ff, "skid full, output empty")
   `Q2E_ASSERT_NEXT(a_skid_holds, skid_valid_ff && rsp_stall, skid_valid_ff, "skid lost")
   `Q2E_ASSERT(a_clamp_pitch, (rsp_valid_ff && rsp_clamped_ff) |-> (rsp_pitch_ff == 15'sd12868 || rsp_pitch_ff == -15'sd12868), "clamped pitch not pi/2")
   `Q2E_ASSERT(a_yaw_range, rsp_valid_ff |-> (rsp_yaw_ff <= PI_Q13 && rsp_yaw_ff >= -PI_Q13), "yaw out of range")

endmodule
